// ----- rtl/core/stun_binding_request_parser_core_defines.svh -----
// Assertion macros shared by the STUN request parser RTL.
// Self-contained; included by the top level only.
`ifndef STUN_BINDING_REQUEST_PARSER_CORE_DEFINES_SVH
`define STUN_BINDING_REQUEST_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define STUNBRP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define STUNBRP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/stunbrp_pkg.sv -----
// Shared types and constants for the STUN Binding Request parser.
// No dependencies.
package stunbrp_pkg;

    localparam int unsigned COUNT_W      = 17;
    localparam int unsigned HEADER_BYTES = 20;
    localparam int unsigned TXID_BYTES   = 12;

    localparam logic [COUNT_W-1:0] COUNT_MAX      = {COUNT_W{1'b1}};
    localparam logic [31:0]        STUN_COOKIE    = 32'h2112A442;
    localparam logic [15:0]        TYPE_BIND_REQ  = 16'h0001;
    localparam logic [7:0]         ATTR_USER_LO   = 8'h06;
    localparam logic [7:0]         ATTR_INTEG_LO  = 8'h08;
    localparam logic [7:0]         COLON_CHAR     = 8'h3A;

    // Header field boundaries, counted in bytes from datagram start.
    localparam int unsigned TYPE_END   = 2;
    localparam int unsigned LEN_END    = 4;
    localparam int unsigned COOKIE_END = 8;
    localparam int unsigned TXHI_END   = COOKIE_END + 4;

    typedef logic [2:0] t_status;
    localparam t_status ST_OK        = 3'd0;
    localparam t_status ST_SHORT     = 3'd1;
    localparam t_status ST_BAD_TYPE  = 3'd2;
    localparam t_status ST_BAD_LEN   = 3'd3;
    localparam t_status ST_BAD_COOKIE = 3'd4;
    localparam t_status ST_ATTR_CUT  = 3'd5;
    localparam t_status ST_USER_FMT  = 3'd6;

    typedef enum logic [2:0] {
        PH_TYPE_HI,
        PH_TYPE_LO,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_VALUE,
        PH_PAD
    } t_phase;

    typedef struct packed {
        t_status     status;
        logic [31:0] txid_upper;
        logic [63:0] txid_lower;
        logic        username_seen;
        logic [15:0] username_start;
        logic [15:0] local_frag_len;
        logic [15:0] remote_frag_len;
        logic        integrity_seen;
        logic [15:0] integrity_offset;
        logic [15:0] message_length;
    } t_result;

endpackage

// ----- rtl/core/stunbrp_parser.sv -----
// Byte-wise STUN header check and attribute walker; builds the result word
// on the last byte of a datagram. Depends on stunbrp_pkg.
module stunbrp_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_data_byte,
    input  logic                i_last_byte,
    output stunbrp_pkg::t_result o_result
);
    import stunbrp_pkg::*;

    logic [COUNT_W-1:0] r_count,      n_count;
    logic [15:0]        r_type,       n_type;
    logic [15:0]        r_len,        n_len;
    logic [31:0]        r_cookie,     n_cookie;
    logic [31:0]        r_txid_hi,    n_txid_hi;
    logic [63:0]        r_txid_lo,    n_txid_lo;
    t_phase             r_phase,      n_phase;
    logic               r_kind_hi0,   n_kind_hi0;
    logic               r_is_user,    n_is_user;
    logic               r_is_integ,   n_is_integ;
    logic [15:0]        r_vlen,       n_vlen;
    logic [15:0]        r_remain,     n_remain;
    logic [1:0]         r_pad,        n_pad;
    logic [1:0]         r_colons,     n_colons;
    logic [15:0]        r_colon_pos,  n_colon_pos;
    logic [15:0]        r_vstart,     n_vstart;
    t_status            r_err,        n_err;
    logic               r_user_seen,  n_user_seen;
    logic [15:0]        r_user_start, n_user_start;
    logic [15:0]        r_user_local, n_user_local;
    logic [15:0]        r_user_rem,   n_user_rem;
    logic               r_integ_seen, n_integ_seen;
    logic [15:0]        r_integ_off,  n_integ_off;

    logic        finish;
    logic [15:0] pos16;
    logic [15:0] len_word;
    t_status     err_final;

    assign pos16    = r_count[15:0];
    assign len_word = {r_vlen[15:8], i_data_byte};

    always_comb begin
        n_type       = r_type;
        n_len        = r_len;
        n_cookie     = r_cookie;
        n_txid_hi    = r_txid_hi;
        n_txid_lo    = r_txid_lo;
        n_phase      = r_phase;
        n_kind_hi0   = r_kind_hi0;
        n_is_user    = r_is_user;
        n_is_integ   = r_is_integ;
        n_vlen       = r_vlen;
        n_remain     = r_remain;
        n_pad        = r_pad;
        n_colons     = r_colons;
        n_colon_pos  = r_colon_pos;
        n_vstart     = r_vstart;
        n_err        = r_err;
        n_user_seen  = r_user_seen;
        n_user_start = r_user_start;
        n_user_local = r_user_local;
        n_user_rem   = r_user_rem;
        n_integ_seen = r_integ_seen;
        n_integ_off  = r_integ_off;
        finish       = 1'b0;

        priority if (r_count < COUNT_W'(TYPE_END)) begin
            n_type = {r_type[7:0], i_data_byte};
        end else if (r_count < COUNT_W'(LEN_END)) begin
            n_len = {r_len[7:0], i_data_byte};
        end else if (r_count < COUNT_W'(COOKIE_END)) begin
            n_cookie = {r_cookie[23:0], i_data_byte};
        end else if (r_count < COUNT_W'(TXHI_END)) begin
            n_txid_hi = {r_txid_hi[23:0], i_data_byte};
        end else if (r_count < COUNT_W'(HEADER_BYTES)) begin
            n_txid_lo = {r_txid_lo[55:0], i_data_byte};
        end else if (r_err == ST_OK) begin
            unique case (r_phase)
                PH_TYPE_HI: begin
                    n_kind_hi0 = (i_data_byte == 8'h00);
                    n_phase    = PH_TYPE_LO;
                end
                PH_TYPE_LO: begin
                    n_is_user  = r_kind_hi0 && (i_data_byte == ATTR_USER_LO);
                    n_is_integ = r_kind_hi0 && (i_data_byte == ATTR_INTEG_LO);
                    n_phase    = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    n_vlen  = {i_data_byte, 8'h00};
                    n_phase = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    n_vlen      = len_word;
                    n_remain    = len_word;
                    n_pad       = 2'd0 - len_word[1:0];
                    n_vstart    = pos16 + 16'd1;
                    n_colons    = 2'd0;
                    n_colon_pos = 16'd0;
                    if (len_word == 16'd0) begin
                        finish = 1'b1;
                    end else begin
                        n_phase = PH_VALUE;
                    end
                end
                PH_VALUE: begin
                    if (r_is_user && (i_data_byte == COLON_CHAR)) begin
                        if (r_colons == 2'd0) n_colon_pos = pos16 - r_vstart;
                        if (r_colons != 2'd2) n_colons = r_colons + 2'd1;
                    end
                    n_remain = r_remain - 16'd1;
                    if (n_remain == 16'd0) finish = 1'b1;
                end
                PH_PAD: begin
                    n_pad = r_pad - 2'd1;
                    if (n_pad == 2'd0) n_phase = PH_TYPE_HI;
                end
                default: begin
                    n_phase = PH_TYPE_HI;
                end
            endcase
        end else begin
            // walk stopped at the first attribute error; bytes are only counted
        end

        // End of an attribute value: record username / integrity info, or flag a malformed username
        if (finish) begin
            if (n_is_user) begin
                if (n_colons != 2'd1) begin
                    n_err = ST_USER_FMT;
                end else begin
                    n_user_seen  = 1'b1;
                    n_user_start = n_vstart;
                    n_user_local = n_colon_pos;
                    n_user_rem   = n_vlen - n_colon_pos - 16'd1;
                end
            end else if (n_is_integ) begin
                n_integ_seen = 1'b1;
                n_integ_off  = n_vstart;
            end
            n_phase = (n_pad != 2'd0) ? PH_PAD : PH_TYPE_HI;
        end

        n_count = (r_count != COUNT_MAX) ? r_count + COUNT_W'(1) : r_count;
    end

    // Final status, evaluated with this byte folded in
    always_comb begin
        err_final = n_err;
        if (n_count >= COUNT_W'(HEADER_BYTES) && n_err == ST_OK &&
            n_phase != PH_TYPE_HI && n_phase != PH_PAD) begin
            err_final = ST_ATTR_CUT;
        end

        o_result = '0;
        priority if (n_count < COUNT_W'(HEADER_BYTES)) begin
            o_result.status = ST_SHORT;
        end else if (n_type != TYPE_BIND_REQ) begin
            o_result.status = ST_BAD_TYPE;
        end else if (({1'b0, n_len} + COUNT_W'(HEADER_BYTES)) != n_count) begin
            o_result.status = ST_BAD_LEN;
        end else if (n_cookie != STUN_COOKIE) begin
            o_result.status = ST_BAD_COOKIE;
        end else begin
            o_result.status = err_final;
        end

        o_result.txid_upper     = n_txid_hi;
        o_result.txid_lower     = n_txid_lo;
        o_result.message_length = n_len;
        if (o_result.status == ST_OK) begin
            o_result.username_seen    = n_user_seen;
            o_result.username_start   = n_user_start;
            o_result.local_frag_len   = n_user_local;
            o_result.remote_frag_len  = n_user_rem;
            o_result.integrity_seen   = n_integ_seen;
            o_result.integrity_offset = n_integ_off;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last_byte)) begin
            r_count      <= '0;
            r_type       <= '0;
            r_len        <= '0;
            r_cookie     <= '0;
            r_txid_hi    <= '0;
            r_txid_lo    <= '0;
            r_phase      <= PH_TYPE_HI;
            r_kind_hi0   <= 1'b0;
            r_is_user    <= 1'b0;
            r_is_integ   <= 1'b0;
            r_vlen       <= '0;
            r_remain     <= '0;
            r_pad        <= '0;
            r_colons     <= '0;
            r_colon_pos  <= '0;
            r_vstart     <= '0;
            r_err        <= ST_OK;
            r_user_seen  <= 1'b0;
            r_user_start <= '0;
            r_user_local <= '0;
            r_user_rem   <= '0;
            r_integ_seen <= 1'b0;
            r_integ_off  <= '0;
        end else if (i_accept) begin
            r_count      <= n_count;
            r_type       <= n_type;
            r_len        <= n_len;
            r_cookie     <= n_cookie;
            r_txid_hi    <= n_txid_hi;
            r_txid_lo    <= n_txid_lo;
            r_phase      <= n_phase;
            r_kind_hi0   <= n_kind_hi0;
            r_is_user    <= n_is_user;
            r_is_integ   <= n_is_integ;
            r_vlen       <= n_vlen;
            r_remain     <= n_remain;
            r_pad        <= n_pad;
            r_colons     <= n_colons;
            r_colon_pos  <= n_colon_pos;
            r_vstart     <= n_vstart;
            r_err        <= n_err;
            r_user_seen  <= n_user_seen;
            r_user_start <= n_user_start;
            r_user_local <= n_user_local;
            r_user_rem   <= n_user_rem;
            r_integ_seen <= n_integ_seen;
            r_integ_off  <= n_integ_off;
        end
    end

endmodule

// ----- rtl/core/stun_binding_request_parser_core.sv -----
// STUN Binding Request parser, top level: byte input channel, result
// output register with skid stage. Depends on stunbrp_pkg, stunbrp_parser
// and stun_binding_request_parser_core_defines.svh.
//
// Usage:
//  - Input channel (i_valid / o_stall) carries one datagram byte per word,
//    with i_last_byte set on the final byte of each datagram.
//  - Output channel (o_valid / i_stall) carries one result word per
//    datagram: status, transaction id, username and integrity info,
//    and the header length field.
//  - Throughput: one byte per cycle while o_stall is low; each byte only updates
//    counters and small registers in a single pass.
//  - Result: the result word is registered into the output register when
//    the last byte is accepted, or into the skid stage if the output is held.
//  - Stall: a result waiting on a stalled output sits in the output
//    register while bytes keep flowing; a second finished result goes
//    into the skid stage, and only then is o_stall raised until the
//    output drains.
//  - Reset (i_rst_n low, synchronous) clears the parser and empties both
//    output stages; the next byte is taken as the start of a datagram.
`include "stun_binding_request_parser_core_defines.svh"

module stun_binding_request_parser_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_last_byte,
    output logic                 o_valid,
    input  logic                 i_stall,
    output stunbrp_pkg::t_status o_status,
    output logic [31:0]          o_txid_upper,
    output logic [63:0]          o_txid_lower,
    output logic                 o_username_seen,
    output logic [15:0]          o_username_start,
    output logic [15:0]          o_local_frag_len,
    output logic [15:0]          o_remote_frag_len,
    output logic                 o_integrity_seen,
    output logic [15:0]          o_integrity_offset,
    output logic [15:0]          o_message_length
);
    import stunbrp_pkg::*;

    logic    in_accept;
    logic    res_valid;
    logic    out_free;
    t_result res_word;

    logic    r_out_valid;
    t_result r_out;
    logic    r_skid_valid;
    t_result r_skid;

    assign o_stall   = r_skid_valid;
    assign in_accept = i_valid && !r_skid_valid;
    assign res_valid = in_accept && i_last_byte;
    assign out_free  = !r_out_valid || !i_stall;

    stunbrp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_result    (res_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            // skid drains first; input is stalled while it is full
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= res_valid;
            end
        end else if (res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : res_word;
        end
        if (!out_free && res_valid) begin
            r_skid <= res_word;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_status           = r_out.status;
    assign o_txid_upper       = r_out.txid_upper;
    assign o_txid_lower       = r_out.txid_lower;
    assign o_username_seen    = r_out.username_seen;
    assign o_username_start   = r_out.username_start;
    assign o_local_frag_len   = r_out.local_frag_len;
    assign o_remote_frag_len  = r_out.remote_frag_len;
    assign o_integrity_seen   = r_out.integrity_seen;
    assign o_integrity_offset = r_out.integrity_offset;
    assign o_message_length   = r_out.message_length;

    `STUNBRP_ASSERT_IMPL(a_skid_implies_out, i_clk, i_rst_n, r_skid_valid, r_out_valid, "skid full with output empty")
    `STUNBRP_ASSERT_NEXT(a_result_shown, i_clk, i_rst_n, res_valid, o_valid, "accepted last byte gave no result")
    `STUNBRP_ASSERT_IMPL(a_err_clears_info, i_clk, i_rst_n, o_valid && (o_status != ST_OK), !o_username_seen && !o_integrity_seen, "error result carries attribute info")
    `STUNBRP_ASSERT_NEXT(a_skid_only_when_full, i_clk, i_rst_n, !r_out_valid, !r_skid_valid, "skid filled while output was empty")

endmodule
